// ===== rtl/core/rsst_pkg.sv =====
// shared types, widths and score helpers for the record sort block
package rsst_pkg;

    localparam int TAG_W           = 16;
    localparam int SCORE_W         = 10;
    localparam int KEY_W           = 12;
    localparam int S_DATA_W        = 48;
    localparam int M_DATA_W        = 32;
    localparam int MAX_RECORDS_DEF = 32;

    localparam logic [SCORE_W-1:0] SCORE_CAP = 10'd1000;

    // one stored record, tag in the low bits
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } record_t;

    // saturate one score at SCORE_CAP, 1000
    function automatic logic [SCORE_W-1:0] clamp_score(input logic [SCORE_W-1:0] s);
        clamp_score = (s > SCORE_CAP) ? SCORE_CAP : s;
    endfunction

    // sum of the three saturated scores, at most 3000
    function automatic logic [KEY_W-1:0] score_total(input logic [SCORE_W-1:0] a,
                                                     input logic [SCORE_W-1:0] b,
                                                     input logic [SCORE_W-1:0] c);
        score_total = KEY_W'(clamp_score(a)) + KEY_W'(clamp_score(b))
                    + KEY_W'(clamp_score(c));
    endfunction

endpackage

// ===== rtl/core/rsst_store.sv =====
// record memory: one write port, one registered read port
module rsst_store #(
    parameter int DEPTH = rsst_pkg::MAX_RECORDS_DEF,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [IDX_W-1:0]     waddr,
    input  rsst_pkg::record_t    wdata,
    input  logic [IDX_W-1:0]     raddr,
    output rsst_pkg::record_t    rdata
);

    rsst_pkg::record_t mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/rsst_ctrl.sv =====
// sequencer: loads records, runs the exchange sort in memory, emits results
module rsst_ctrl #(
    parameter int MAX_RECORDS = rsst_pkg::MAX_RECORDS_DEF,
    parameter int IDX_W       = $clog2(MAX_RECORDS),
    parameter int CNT_W       = $clog2(MAX_RECORDS + 1)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rsst_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rsst_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                           m_tlast,
    output logic                           m_tuser,
    output logic                           mem_we,
    output logic [IDX_W-1:0]               mem_waddr,
    output rsst_pkg::record_t              mem_wdata,
    output logic [IDX_W-1:0]               mem_raddr,
    input  rsst_pkg::record_t              mem_rdata
);

    localparam logic [2:0] ST_LOAD = 3'd0;
    localparam logic [2:0] ST_RDI  = 3'd1;
    localparam logic [2:0] ST_LDI  = 3'd2;
    localparam logic [2:0] ST_CMP  = 3'd3;
    localparam logic [2:0] ST_WRI  = 3'd4;
    localparam logic [2:0] ST_ERD  = 3'd5;
    localparam logic [2:0] ST_ELD  = 3'd6;
    localparam logic [2:0] ST_EWT  = 3'd7;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RECORDS);

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              drop_reg, drop_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    rsst_pkg::record_t cur_reg, cur_next;
    rsst_pkg::record_t out_rec_reg, out_rec_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_last_reg, out_last_next;

    logic              s_accept;
    logic              store_full;
    logic              swap;
    logic              j_at_end;
    logic              i_at_end;
    logic              k_at_end;
    rsst_pkg::record_t in_rec;

    // input record with its key
    assign in_rec.tag = s_tdata[15:0];
    assign in_rec.key = rsst_pkg::score_total(s_tdata[25:16], s_tdata[35:26],
                                              s_tdata[45:36]);

    assign s_tready   = (state_reg == ST_LOAD);
    assign s_accept   = s_tvalid && s_tready;
    assign store_full = (count_reg == CNT_MAX);
    assign swap       = (cur_reg.key < mem_rdata.key);
    assign j_at_end   = ((CNT_W'(j_reg) + CNT_W'(1)) == count_reg);
    assign i_at_end   = ((CNT_W'(i_reg) + CNT_W'(2)) == count_reg);
    assign k_at_end   = ((CNT_W'(i_reg) + CNT_W'(1)) == count_reg);

    // output channel
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(rsst_pkg::M_DATA_W - rsst_pkg::KEY_W - rsst_pkg::TAG_W){1'b0}},
                       out_rec_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = drop_reg;

    // next state and memory access
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        drop_next      = drop_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        cur_next       = cur_reg;
        out_rec_next   = out_rec_reg;
        out_valid_next = out_valid_reg;
        out_last_next  = out_last_reg;
        mem_we         = 1'b0;
        mem_waddr      = count_reg[IDX_W-1:0];
        mem_wdata      = in_rec;
        mem_raddr      = i_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (s_accept)
                begin
                    if (store_full)
                    begin
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (s_tlast)
                    begin
                        i_next     = '0;
                        // a lone record needs no sorting
                        state_next = (count_reg == '0) ? ST_ERD : ST_RDI;
                    end
                end
            end
            ST_RDI:
            begin
                mem_raddr  = i_reg;
                j_next     = i_reg + IDX_W'(1);
                state_next = ST_LDI;
            end
            ST_LDI:
            begin
                cur_next   = mem_rdata;
                mem_raddr  = j_reg;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                // record j arrives; read j+1 ahead
                mem_raddr = j_reg + IDX_W'(1);
                if (swap)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = j_reg;
                    mem_wdata = cur_reg;
                    cur_next  = mem_rdata;
                end
                if (j_at_end)
                begin
                    state_next = ST_WRI;
                end
                else
                begin
                    j_next = j_reg + IDX_W'(1);
                end
            end
            ST_WRI:
            begin
                // position i is settled; start the next pass or, after the last pass, the emission
                mem_we    = 1'b1;
                mem_waddr = i_reg;
                mem_wdata = cur_reg;
                mem_raddr = i_reg + IDX_W'(1);
                if (i_at_end)
                begin
                    i_next     = '0;
                    state_next = ST_ERD;
                end
                else
                begin
                    i_next     = i_reg + IDX_W'(1);
                    j_next     = i_reg + IDX_W'(2);
                    state_next = ST_LDI;
                end
            end
            ST_ERD:
            begin
                mem_raddr  = i_reg;
                state_next = ST_ELD;
            end
            ST_ELD:
            begin
                out_rec_next   = mem_rdata;
                out_valid_next = 1'b1;
                out_last_next  = k_at_end;
                state_next     = ST_EWT;
            end
            ST_EWT:
            begin
                if (m_tready)
                begin
                    out_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        count_next = '0;
                        drop_next  = 1'b0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        i_next     = i_reg + IDX_W'(1);
                        state_next = ST_ERD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload and index registers
    always_ff @(posedge clk)
    begin
        i_reg        <= i_next;
        j_reg        <= j_next;
        cur_reg      <= cur_next;
        out_rec_reg  <= out_rec_next;
        out_last_reg <= out_last_next;
    end

`ifndef SYNTH
    // no input is taken while a result is pending
    assert property (@(posedge clk) disable iff (!rst_n) m_tvalid |-> !s_tready)
        else $error("input ready while a result is pending");

    // the fill count never passes the capacity
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_MAX)
        else $error("record count beyond capacity");

    // a sort write never hits the entry being read ahead
    assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && (state_reg == ST_CMP || state_reg == ST_WRI)) |-> mem_waddr != mem_raddr)
        else $error("sort write collides with read");

    // the last result clears the load state
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (count_reg == '0 && !drop_reg && s_tready))
        else $error("load state not cleared after the list");
`endif

endmodule

// ===== rtl/core/record_sort_by_score_total.sv =====
// top level of the record sort block: sequencer and record memory
//
// Records arrive on the s_ channel, one per request: tag and three scores
// in hundredths, each score saturated to 1000 before summing. s_tlast marks
// the last record of a set. Up to MAX_RECORDS records are held; a record
// arriving when the store is full is dropped and the set is flagged.
// After the last record the stored set is sorted in the record memory by an
// exchange sort, position i held in a register while entry j is read,
// compared and written back; the memory has a single read port. The results
// then leave on the m_ channel in descending order of total, each result
// read from the memory only after the previous one is taken; m_tlast marks
// the last, m_tuser flags a set with dropped records. s_tready is low from
// the end of the set until the last result is taken. A stalled receiver
// simply holds the current result and pauses the emission. Reset empties
// the store and clears the drop flag; the memory itself needs no clearing.
module record_sort_by_score_total #(
    parameter int MAX_RECORDS = rsst_pkg::MAX_RECORDS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // fields from bit 0: record_tag 16, score_a 10, score_b 10, score_c 10, zero 2
    input  logic [rsst_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // fields from bit 0: out_tag 16, total_score 12, zero 4
    output logic [rsst_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                           m_tlast,
    // fields from bit 0: overflowed 1
    output logic                           m_tuser
);

    localparam int IDX_W = $clog2(MAX_RECORDS);
    localparam int CNT_W = $clog2(MAX_RECORDS + 1);

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [IDX_W-1:0]  mem_raddr;
    rsst_pkg::record_t mem_wdata;
    rsst_pkg::record_t mem_rdata;

    // load, sort and emit sequencer
    rsst_ctrl #(
        .MAX_RECORDS (MAX_RECORDS),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // key and tag memory
    rsst_store #(
        .DEPTH (MAX_RECORDS),
        .IDX_W (IDX_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule
